// ----- rtl/info_frame_builder_byte_stuffing_assert.svh -----
// Assertion macros for the info frame builder.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INFO_FRAME_BUILDER_BYTE_STUFFING_ASSERT_SVH
`define INFO_FRAME_BUILDER_BYTE_STUFFING_ASSERT_SVH
`ifndef SYNTHESIS
`define IFBBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define IFBBS_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define IFBBS_ASSERT(lbl, clk, rst_n, prop)
`define IFBBS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/ifbbs_pkg.sv -----
// Shared constants, request type and sequencer phases for the info frame builder.
// Depends on nothing.
package ifbbs_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam logic REG_ADDRESS_BYTE = 1'b0;

  typedef struct packed {
    logic       open;
    logic       seq;
    logic       last;
    logic [7:0] data;
    logic [7:0] check;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [8:0] {
    PH_FLAG_OPEN  = 9'b000000001,
    PH_ADDR       = 9'b000000010,
    PH_CTRL       = 9'b000000100,
    PH_HCHK       = 9'b000001000,
    PH_DATA       = 9'b000010000,
    PH_DATA_ESC   = 9'b000100000,
    PH_CHK        = 9'b001000000,
    PH_CHK_ESC    = 9'b010000000,
    PH_FLAG_CLOSE = 9'b100000000
  } phase_t;

  function automatic logic is_special(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
  endfunction

endpackage

// ----- rtl/info_frame_builder_byte_stuffing.sv -----
// Info frame builder with byte stuffing: top level, config register and wiring.
// Depends on ifbbs_pkg, ifbbs_front, ifbbs_fifo and ifbbs_back.
//
// Input channel (in_valid/in_stall): one payload byte per request with a last
// mark and a sequence bit; the first byte of a frame opens it with flag,
// address, control and header check. The last byte adds the stuffed XOR check
// and the closing flag. Output channel (out_valid/out_stall): one framed,
// stuffed byte per request, out_run_last on the final byte of each input.
// A four-entry request queue sits between the input front end and the byte
// sequencer, so input is taken while output bytes wait.
// An input byte is written into the request queue; its first output byte then
// goes through the output register. The sequencer emits one byte per cycle
// while requests wait and out_stall is low; an input gives 1 to 9 bytes (1
// plain, 2 escaped, 4 more on open, 2 to 3 more on close). Input stalls only when
// the queue fills. Reset clears the frame state, queue and output valid, and
// sets the address register to 0x03. A stalled output holds its byte.
// Config: APB register 0 (byte addresses 0 to 3) holds the address byte.
module info_frame_builder_byte_stuffing (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  input  logic                            in_seq_bit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_frame_end,
  output logic                            out_run_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ifbbs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [7:0]         addr_r;
  logic               reg_sel;
  logic               push, pop;
  ifbbs_pkg::req_t    push_req, head_req;
  ifbbs_pkg::q_stat_t q_stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ifbbs_pkg::PADDR_W-1] == ifbbs_pkg::REG_ADDRESS_BYTE);
  assign prdata  = reg_sel ? {24'h000000, addr_r} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ifbbs_pkg::ADDR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      addr_r <= pwdata[7:0];
    end
  end

  ifbbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_seq_bit   (in_seq_bit),
    .q_stat       (q_stat),
    .push         (push),
    .push_req     (push_req)
  );

  ifbbs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head_req (head_req),
    .q_stat   (q_stat)
  );

  ifbbs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .address_byte  (addr_r),
    .head_req      (head_req),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule

// ----- rtl/ifbbs_front.sv -----
// Front end: accepts payload bytes, tracks frame state and running XOR,
// and turns each byte into a request for the queue. Uses ifbbs_pkg.
module ifbbs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  in_seq_bit,
  input  ifbbs_pkg::q_stat_t    q_stat,
  output logic                  push,
  output ifbbs_pkg::req_t       push_req
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic [7:0] chk_sum;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign chk_sum  = (in_frame_r ? chk_r : 8'h00) ^ in_data_byte;

  always_comb begin
    push_req.open  = !in_frame_r;
    push_req.seq   = in_seq_bit;
    push_req.last  = in_last_byte;
    push_req.data  = in_data_byte;
    push_req.check = chk_sum;
    in_frame_nxt   = in_frame_r;
    chk_nxt        = chk_r;
    if (push) begin
      in_frame_nxt = !in_last_byte;
      chk_nxt      = in_last_byte ? 8'h00 : chk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      chk_r      <= 8'h00;
    end else begin
      in_frame_r <= in_frame_nxt;
      chk_r      <= chk_nxt;
    end
  end

endmodule

// ----- rtl/ifbbs_fifo.sv -----
// Request queue between front and back ends.
// Uses ifbbs_pkg for the request type and depth.
`include "info_frame_builder_byte_stuffing_assert.svh"
module ifbbs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ifbbs_pkg::req_t     push_req,
  input  logic                pop,
  output ifbbs_pkg::req_t     head_req,
  output ifbbs_pkg::q_stat_t  q_stat
);

  ifbbs_pkg::req_t mem [ifbbs_pkg::QDEPTH];
  logic [ifbbs_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ifbbs_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == ifbbs_pkg::QCNT_W'(ifbbs_pkg::QDEPTH));
  assign head_req     = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `IFBBS_NEVER(a_no_push_full, clk, rst_n, push && q_stat.full)
  `IFBBS_NEVER(a_no_pop_empty, clk, rst_n, pop && q_stat.empty)
  `IFBBS_ASSERT(a_cnt_in_range, clk, rst_n, cnt_r <= ifbbs_pkg::QCNT_W'(ifbbs_pkg::QDEPTH))

endmodule

// ----- rtl/ifbbs_back.sv -----
// Back end: walks each queued request through header (frame open only), stuffed
// data, then stuffed check and closing flag (last byte only), one byte per cycle
// into the output register while the output is not stalled. Uses ifbbs_pkg.
`include "info_frame_builder_byte_stuffing_assert.svh"
module ifbbs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          address_byte,
  input  ifbbs_pkg::req_t     head_req,
  input  ifbbs_pkg::q_stat_t  q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_frame_end,
  output logic                out_run_last
);

  ifbbs_pkg::phase_t phase_r, phase_nxt, cur;
  logic       busy_r, busy_nxt;
  logic       emit;
  logic [7:0] ctrl;
  logic [7:0] byte_c;
  logic       end_c, last_c;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_frame_end_r, out_run_last_r;

  assign cur  = busy_r ? phase_r
                       : (head_req.open ? ifbbs_pkg::PH_FLAG_OPEN : ifbbs_pkg::PH_DATA);
  assign ctrl = head_req.seq ? ifbbs_pkg::CTRL_SEQ1 : ifbbs_pkg::CTRL_SEQ0;
  assign emit = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop  = emit && last_c;

  always_comb begin
    byte_c    = ifbbs_pkg::FLAG_BYTE;
    end_c     = 1'b0;
    last_c    = 1'b0;
    phase_nxt = cur;
    case (cur)
      ifbbs_pkg::PH_FLAG_OPEN: begin
        byte_c    = ifbbs_pkg::FLAG_BYTE;
        phase_nxt = ifbbs_pkg::PH_ADDR;
      end
      ifbbs_pkg::PH_ADDR: begin
        byte_c    = address_byte;
        phase_nxt = ifbbs_pkg::PH_CTRL;
      end
      ifbbs_pkg::PH_CTRL: begin
        byte_c    = ctrl;
        phase_nxt = ifbbs_pkg::PH_HCHK;
      end
      ifbbs_pkg::PH_HCHK: begin
        byte_c    = address_byte ^ ctrl;
        phase_nxt = ifbbs_pkg::PH_DATA;
      end
      ifbbs_pkg::PH_DATA: begin
        if (ifbbs_pkg::is_special(head_req.data)) begin
          byte_c    = ifbbs_pkg::ESC_BYTE;
          phase_nxt = ifbbs_pkg::PH_DATA_ESC;
        end else begin
          byte_c    = head_req.data;
          phase_nxt = ifbbs_pkg::PH_CHK;
          last_c    = !head_req.last;
        end
      end
      ifbbs_pkg::PH_DATA_ESC: begin
        byte_c    = ifbbs_pkg::esc_code(head_req.data);
        phase_nxt = ifbbs_pkg::PH_CHK;
        last_c    = !head_req.last;
      end
      ifbbs_pkg::PH_CHK: begin
        if (ifbbs_pkg::is_special(head_req.check)) begin
          byte_c    = ifbbs_pkg::ESC_BYTE;
          phase_nxt = ifbbs_pkg::PH_CHK_ESC;
        end else begin
          byte_c    = head_req.check;
          phase_nxt = ifbbs_pkg::PH_FLAG_CLOSE;
        end
      end
      ifbbs_pkg::PH_CHK_ESC: begin
        byte_c    = ifbbs_pkg::esc_code(head_req.check);
        phase_nxt = ifbbs_pkg::PH_FLAG_CLOSE;
      end
      ifbbs_pkg::PH_FLAG_CLOSE: begin
        byte_c = ifbbs_pkg::FLAG_BYTE;
        end_c  = 1'b1;
        last_c = 1'b1;
      end
      default: begin
        byte_c = ifbbs_pkg::FLAG_BYTE;
        last_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (emit) begin
      busy_nxt = !last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= ifbbs_pkg::PH_DATA;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit) begin
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r      <= byte_c;
      out_frame_end_r <= end_c;
      out_run_last_r  <= last_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;
  assign out_run_last  = out_run_last_r;

  `IFBBS_ASSERT(a_end_is_last_flag, clk, rst_n,
    (out_valid_r && out_frame_end_r) |-> (out_run_last_r && out_byte_r == ifbbs_pkg::FLAG_BYTE))
  `IFBBS_NEVER(a_busy_needs_req, clk, rst_n, busy_r && q_stat.empty)
  `IFBBS_ASSERT(a_pop_ends_run, clk, rst_n, pop |=> (out_valid_r && out_run_last_r))

endmodule
